>>> hw/rtl/priority_job_dispatcher_unit_defines.svh
// Assertion macros used by the dispatcher back end.
`ifndef PRIORITY_JOB_DISPATCHER_UNIT_DEFINES_SVH
`define PRIORITY_JOB_DISPATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PJD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispatcher assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PJD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispatcher assertion failed");

`endif

>>> hw/rtl/pjd_pkg.sv
// Types, codes and a helper function of the job dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package pjd_pkg;

    localparam int MAX_WORKERS_DEF = 16;
    localparam int FIFO_DEPTH_DEF  = 128;

    // Input commands
    localparam logic [1:0] CMD_SUBMIT   = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_FREE     = 2'd2;

    // Priorities
    localparam logic [1:0] PRIO_NONE = 2'd0;
    localparam logic [1:0] PRIO_HIGH = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_DISPATCHED = 3'd0;
    localparam logic [2:0] ST_QUEUED     = 3'd1;
    localparam logic [2:0] ST_REJECTED   = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_ASSIGNED   = 3'd4;
    localparam logic [2:0] ST_FREED      = 3'd5;

    // Classified command kinds
    localparam logic [1:0] KIND_NOP      = 2'd0;
    localparam logic [1:0] KIND_SUBMIT   = 2'd1;
    localparam logic [1:0] KIND_DISPATCH = 2'd2;
    localparam logic [1:0] KIND_FREE     = 2'd3;

    // Configuration register indexes
    localparam logic CFG_WORKER_COUNT = 1'b0;
    localparam logic CFG_MULTITHREAD  = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] job_type;
        logic [1:0] priority_req;
        logic       has_dependencies;
        logic [3:0] worker_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] job_handle;
        logic [3:0]  assigned_worker;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       reject;
        logic       immediate;
        logic [1:0] queue_sel;
        logic [2:0] job_type;
        logic [3:0] worker_index;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

    // Type mask of worker w for the current configuration.
    function automatic logic [2:0] worker_mask(input logic [3:0] w,
                                               input logic [4:0] wc,
                                               input logic mt);
        logic [2:0] m;
        if (wc == 5'd1 || !mt)
            m = (w == 4'd0) ? 3'd7 : 3'd1;
        else if (wc == 5'd2)
            m = (w == 4'd0) ? 3'd3 : 3'd5;
        else if (w == 4'd0)
            m = 3'd2;
        else if (w == 4'd1)
            m = 3'd4;
        else
            m = 3'd1;
        return m;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pjd_front.sv
// Front end: accepts items, classifies them and holds them in a short queue.
`timescale 1ns / 1ps
`default_nettype none
module pjd_front #(
    parameter int MAX_WORKERS = pjd_pkg::MAX_WORKERS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pjd_pkg::in_item_t  in_item,
    output pjd_pkg::cmd_chan_t      cmd_out,
    input  wire logic               cmd_pop
);
    pjd_pkg::cmd_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    pjd_pkg::cmd_t cls;
    logic push;

    // Classify the incoming item
    always_comb
    begin
        cls = '0;
        cls.job_type     = in_item.job_type;
        cls.worker_index = in_item.worker_index;
        cls.reject       = (in_item.priority_req == pjd_pkg::PRIO_NONE);
        cls.immediate    = (in_item.priority_req == pjd_pkg::PRIO_HIGH) &&
                           !in_item.has_dependencies;
        cls.queue_sel    = 2'd3 - in_item.priority_req;
        unique case (in_item.command)
            pjd_pkg::CMD_SUBMIT:   cls.kind = pjd_pkg::KIND_SUBMIT;
            pjd_pkg::CMD_DISPATCH: cls.kind = pjd_pkg::KIND_DISPATCH;
            pjd_pkg::CMD_FREE:
                cls.kind = ({1'b0, in_item.worker_index} < 5'(MAX_WORKERS)) ?
                           pjd_pkg::KIND_FREE : pjd_pkg::KIND_NOP;
            default:               cls.kind = pjd_pkg::KIND_NOP;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign cmd_out.valid = (cnt_reg != 2'd0);
    assign cmd_out.cmd   = slot_reg[rd_reg];

    // Advance queue pointers
    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        if (push)
            wr_next = !wr_reg;
        if (cmd_pop && cmd_out.valid)
            rd_next = !rd_reg;
        if (push && !(cmd_pop && cmd_out.valid))
            cnt_next = cnt_reg + 2'd1;
        else if (!push && cmd_pop && cmd_out.valid)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    // Store the classified item
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= cls;
    end
endmodule
`default_nettype wire

>>> hw/rtl/pjd_back.sv
// Back end: worker state, priority FIFOs and the dispatch sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_job_dispatcher_unit_defines.svh"
module pjd_back #(
    parameter int MAX_WORKERS = pjd_pkg::MAX_WORKERS_DEF,
    parameter int FIFO_DEPTH  = pjd_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pjd_pkg::cmd_chan_t cmd_in,
    output logic                    cmd_pop,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [4:0]         cfg_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pjd_pkg::out_item_t      out_item
);
    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [18:0] fifo_mem [3][FIFO_DEPTH];

    logic [1:0]  state_reg, state_next;
    logic [1:0]  qi_reg, qi_next;
    logic [AW-1:0] rp_reg [3];
    logic [AW-1:0] rp_next [3];
    logic [AW-1:0] wp_reg [3];
    logic [AW-1:0] wp_next [3];
    logic [CW-1:0] cnt_reg [3];
    logic [CW-1:0] cnt_next [3];
    logic [MAX_WORKERS-1:0] busy_reg, busy_next;
    logic [15:0] handle_reg, handle_next;
    logic [4:0]  wc_reg;
    logic        mt_reg;
    logic [18:0] rd_data_reg;
    logic        pend_valid_reg, pend_valid_next;
    pjd_pkg::out_item_t pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;
    pjd_pkg::out_item_t out_reg, out_next;

    logic [2:0]  find_type;
    logic        found;
    logic [3:0]  fw;
    logic        out_free;
    logic        mem_we;
    logic        pop_fire;
    pjd_pkg::cmd_t c;

    assign c         = cmd_in.cmd;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // Find lowest free active worker matching the type
    assign find_type = (state_reg == S_IDLE) ? c.job_type : rd_data_reg[2:0];
    always_comb
    begin
        found = 1'b0;
        fw    = '0;
        for (int i = MAX_WORKERS - 1; i >= 0; i--)
        begin
            if ((5'(i) < wc_reg) && !busy_reg[i] &&
                ((pjd_pkg::worker_mask(4'(i), wc_reg, mt_reg) & find_type) != 3'd0))
            begin
                found = 1'b1;
                fw    = 4'(i);
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        qi_next         = qi_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        cnt_next        = cnt_reg;
        busy_next       = busy_reg;
        handle_next     = handle_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        pop_fire        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_in.valid)
                begin
                    unique case (c.kind)
                        pjd_pkg::KIND_NOP:
                            cmd_pop = 1'b1;
                        pjd_pkg::KIND_FREE:
                        begin
                            if (out_free)
                            begin
                                cmd_pop = 1'b1;
                                for (int i = 0; i < MAX_WORKERS; i++)
                                    if (4'(i) == c.worker_index)
                                        busy_next[i] = 1'b0;
                                out_valid_next = 1'b1;
                                out_next = '{pjd_pkg::ST_FREED, 16'd0, c.worker_index, 1'b1};
                            end
                        end
                        pjd_pkg::KIND_SUBMIT:
                        begin
                            if (out_free)
                            begin
                                cmd_pop        = 1'b1;
                                handle_next    = handle_reg + 16'd1;
                                out_valid_next = 1'b1;
                                out_next = '{pjd_pkg::ST_QUEUED, handle_reg, 4'd0, 1'b1};
                                if (c.reject)
                                    out_next.status = pjd_pkg::ST_REJECTED;
                                else if (c.immediate && found)
                                begin
                                    for (int i = 0; i < MAX_WORKERS; i++)
                                        if (4'(i) == fw)
                                            busy_next[i] = 1'b1;
                                    out_next.status          = pjd_pkg::ST_DISPATCHED;
                                    out_next.assigned_worker = fw;
                                end
                                else if (cnt_reg[c.queue_sel] == CW'(FIFO_DEPTH))
                                    out_next.status = pjd_pkg::ST_FULL;
                                else
                                begin
                                    mem_we = 1'b1;
                                    wp_next[c.queue_sel]  = ptr_inc(wp_reg[c.queue_sel]);
                                    cnt_next[c.queue_sel] = cnt_reg[c.queue_sel] + CW'(1);
                                end
                            end
                        end
                        pjd_pkg::KIND_DISPATCH:
                        begin
                            cmd_pop    = 1'b1;
                            qi_next    = 2'd0;
                            state_next = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:
            begin
                // Skip an empty queue, otherwise read its head
                if (cnt_reg[qi_reg] == '0)
                begin
                    if (qi_reg == 2'd2)
                        state_next = S_FIN;
                    else
                        qi_next = qi_reg + 2'd1;
                end
                else
                    state_next = S_EV;
            end
            S_EV:
            begin
                if (!found)
                begin
                    if (qi_reg == 2'd2)
                        state_next = S_FIN;
                    else
                    begin
                        qi_next    = qi_reg + 2'd1;
                        state_next = S_RD;
                    end
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // Release the held result, hold the new one
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                    end
                    pop_fire        = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_next = '{pjd_pkg::ST_ASSIGNED, rd_data_reg[18:3], fw, 1'b0};
                    for (int i = 0; i < MAX_WORKERS; i++)
                        if (4'(i) == fw)
                            busy_next[i] = 1'b1;
                    rp_next[qi_reg]  = ptr_inc(rp_reg[qi_reg]);
                    cnt_next[qi_reg] = cnt_reg[qi_reg] - CW'(1);
                    state_next       = S_RD;
                end
            end
            S_FIN:
            begin
                if (!pend_valid_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            qi_reg         <= '0;
            rp_reg         <= '{default: '0};
            wp_reg         <= '{default: '0};
            cnt_reg        <= '{default: '0};
            busy_reg       <= '0;
            handle_reg     <= '0;
            wc_reg         <= 5'd1;
            mt_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            qi_reg         <= qi_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            cnt_reg        <= cnt_next;
            busy_reg       <= busy_next;
            handle_reg     <= handle_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            // Configuration writes, worker count saturates and a zero becomes one
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pjd_pkg::CFG_WORKER_COUNT:
                    begin
                        if (cfg_data == 5'd0)
                            wc_reg <= 5'd1;
                        else if (cfg_data > 5'(MAX_WORKERS))
                            wc_reg <= 5'(MAX_WORKERS);
                        else
                            wc_reg <= cfg_data;
                    end
                    pjd_pkg::CFG_MULTITHREAD:
                        mt_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // FIFO storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            fifo_mem[c.queue_sel][wp_reg[c.queue_sel]] <= {handle_reg, c.job_type};
        if (state_reg == S_RD)
            rd_data_reg <= fifo_mem[qi_reg][rp_reg[qi_reg]];
    end

    `PJD_ASSERT_IMPL(a_eval_nonempty, clk, rst_n, state_reg == S_EV, cnt_reg[qi_reg] != '0)
    `PJD_ASSERT_IMPL(a_idle_no_pend, clk, rst_n, state_reg == S_IDLE, !pend_valid_reg)
    `PJD_ASSERT_NEXT(a_pop_claims, clk, rst_n, pop_fire, $countones(busy_reg) == $countones($past(busy_reg)) + 1)
endmodule
`default_nettype wire

>>> hw/rtl/priority_job_dispatcher_unit.sv
// Top level of the strict-priority job dispatcher.
// Usage:
//   Input channel (in_valid/in_ready/in_item) takes submit, dispatch-pass and
//   worker-finished commands; output channel (out_valid/out_ready/out_item)
//   returns result items, the last one of each command flagged by last.
//   Configuration (cfg_we/cfg_index/cfg_data) is written while idle.
// Flow:
//   An accepted item sits in a two-entry command queue, which keeps taking
//   items while the back end is busy. The back end takes an item in idle; a
//   submit or finish also waits for a free result register, which then holds
//   its result. A dispatch pass reads and evaluates each FIFO head, skips
//   an empty FIFO and ends with a closing step; its results appear one
//   behind the assignments that make them, paced by the single read port.
// Reset: FIFOs empty, all workers free, handle counter zero, worker count 1,
//   multithreaded renderer off. FIFO contents are not cleared.
// Stall: while out_ready is low the result register holds; the back end
//   waits at its next result, the command queue fills, then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module priority_job_dispatcher_unit #(
    parameter int MAX_WORKERS = pjd_pkg::MAX_WORKERS_DEF,
    parameter int FIFO_DEPTH  = pjd_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pjd_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pjd_pkg::out_item_t      out_item,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [4:0]         cfg_data
);
    pjd_pkg::cmd_chan_t cmd_chan;
    logic cmd_pop;

    pjd_front #(
        .MAX_WORKERS(MAX_WORKERS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .cmd_out  (cmd_chan),
        .cmd_pop  (cmd_pop)
    );

    pjd_back #(
        .MAX_WORKERS(MAX_WORKERS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (cmd_chan),
        .cmd_pop   (cmd_pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );
endmodule
`default_nettype wire

>>> dv/priority_job_dispatcher_unit_tb.sv
// Self-checking testbench for the strict-priority job dispatcher.
`timescale 1ns / 1ps
`default_nettype none
module priority_job_dispatcher_unit_tb;

    localparam int NUM_WORKERS = 16;
    localparam int QUEUE_DEPTH = 128;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] PRIO_LOW    = 2'd1;
    localparam logic [1:0] PRIO_NORMAL = 2'd2;

    typedef struct packed {
        logic [15:0] handle;
        logic [2:0]  jtype;
    } waiting_job_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    pjd_pkg::in_item_t   in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    pjd_pkg::out_item_t  out_item;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;

    // Dispatcher state as predicted
    waiting_job_t job_queue [3][$];
    logic [15:0]  busy_mask;
    logic [15:0]  handle_ctr;
    int           active_workers;
    logic         multithread;

    pjd_pkg::in_item_t  pending_items[$];
    pjd_pkg::out_item_t expected_results[$];
    int        errors = 0;
    int        items_sent = 0;
    int        results_seen = 0;
    bit        calm = 0;
    int        send_gap = 0;
    int        recv_stall = 0;
    int        quiet_cycles = 0;

    priority_job_dispatcher_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [2:0] type_mask_of(int w);
        if (active_workers == 1 || !multithread)
            return (w == 0) ? 3'd7 : 3'd1;
        if (active_workers == 2)
            return (w == 0) ? 3'd3 : 3'd5;
        if (w == 0)
            return 3'd2;
        if (w == 1)
            return 3'd4;
        return 3'd1;
    endfunction

    // Lowest free active worker whose mask matches, or -1
    function automatic int pick_worker(logic [2:0] jtype);
        for (int w = 0; w < active_workers; w++)
        begin
            if ((type_mask_of(w) & jtype) != 0 && !busy_mask[w])
                return w;
        end
        return -1;
    endfunction

    function automatic pjd_pkg::out_item_t make_result(logic [2:0] st, logic [15:0] h,
                                                       int w);
        pjd_pkg::out_item_t r;
        r.status = st;
        r.job_handle = h;
        r.assigned_worker = w[3:0];
        r.last = 1'b0;
        return r;
    endfunction

    // Work out the results of one accepted item
    task automatic predict_dispatch(pjd_pkg::in_item_t it);
        pjd_pkg::out_item_t res[$];
        logic [15:0]  h;
        int           w;
        int           q;
        waiting_job_t job;
        res = {};
        case (it.command)
            pjd_pkg::CMD_SUBMIT:
            begin
                h = handle_ctr;
                handle_ctr = handle_ctr + 16'd1;
                if (it.priority_req == pjd_pkg::PRIO_NONE)
                    res.push_back(make_result(pjd_pkg::ST_REJECTED, h, 0));
                else
                begin
                    w = -1;
                    if (it.priority_req == pjd_pkg::PRIO_HIGH && !it.has_dependencies)
                        w = pick_worker(it.job_type);
                    if (w >= 0)
                    begin
                        busy_mask[w] = 1'b1;
                        res.push_back(make_result(pjd_pkg::ST_DISPATCHED, h, w));
                    end
                    else
                    begin
                        q = 3 - int'(it.priority_req);
                        if (job_queue[q].size() >= QUEUE_DEPTH)
                            res.push_back(make_result(pjd_pkg::ST_FULL, h, 0));
                        else
                        begin
                            job.handle = h;
                            job.jtype = it.job_type;
                            job_queue[q].push_back(job);
                            res.push_back(make_result(pjd_pkg::ST_QUEUED, h, 0));
                        end
                    end
                end
            end
            pjd_pkg::CMD_DISPATCH:
            begin
                for (q = 0; q < 3; q++)
                begin
                    while (job_queue[q].size() > 0 && res.size() < NUM_WORKERS)
                    begin
                        w = pick_worker(job_queue[q][0].jtype);
                        if (w < 0)
                            break;
                        busy_mask[w] = 1'b1;
                        job = job_queue[q].pop_front();
                        res.push_back(make_result(pjd_pkg::ST_ASSIGNED, job.handle, w));
                    end
                end
            end
            pjd_pkg::CMD_FREE:
            begin
                busy_mask[it.worker_index] = 1'b0;
                res.push_back(make_result(pjd_pkg::ST_FREED, 16'd0, it.worker_index));
            end
            default: ;
        endcase
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            expected_results.push_back(res[i]);
    endtask

    // Driver: hold the item until accepted, insert random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_dispatch(in_item);
                items_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 18);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random, compare each item with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status=%0d handle=%0d worker=%0d",
                           out_item.status, out_item.job_handle, out_item.assigned_worker);
                    errors++;
                end
                else
                begin
                    pjd_pkg::out_item_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (out_item.status !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, out_item.status);
                        errors++;
                    end
                    if (out_item.job_handle !== exp_r.job_handle)
                    begin
                        $error("job_handle: expected %0d, got %0d",
                               exp_r.job_handle, out_item.job_handle);
                        errors++;
                    end
                    if (out_item.assigned_worker !== exp_r.assigned_worker)
                    begin
                        $error("assigned_worker: expected %0d, got %0d",
                               exp_r.assigned_worker, out_item.assigned_worker);
                        errors++;
                    end
                    if (out_item.last !== exp_r.last)
                    begin
                        $error("last: expected %0d, got %0d", exp_r.last, out_item.last);
                        errors++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    recv_stall = $urandom_range(1, 18);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else if (rst_n)
        begin
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding",
                         expected_results.size());
                $display("Regression FAIL");
                $finish;
            end
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic pjd_pkg::in_item_t mk_item(logic [1:0] cmd, logic [2:0] jt,
                                                  logic [1:0] pr, logic dep,
                                                  logic [3:0] widx);
        pjd_pkg::in_item_t it;
        it.command = cmd;
        it.job_type = jt;
        it.priority_req = pr;
        it.has_dependencies = dep;
        it.worker_index = widx;
        return it;
    endfunction

    // Random item; type zero only goes to the low queue or is rejected
    function automatic pjd_pkg::in_item_t random_item(int flood);
        pjd_pkg::in_item_t it;
        int       pick;
        it = pjd_pkg::in_item_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < (flood ? 75 : 45))
            it.command = pjd_pkg::CMD_SUBMIT;
        else if (pick < (flood ? 82 : 68))
            it.command = pjd_pkg::CMD_DISPATCH;
        else if (pick < 96)
            it.command = pjd_pkg::CMD_FREE;
        else
            it.command = CMD_UNUSED;
        if (flood && $urandom_range(0, 3) != 0)
            it.priority_req = PRIO_LOW;
        if (it.priority_req != pjd_pkg::PRIO_NONE && it.priority_req != PRIO_LOW &&
            it.job_type == 3'd0)
            it.job_type = 3'($urandom_range(1, 7));
        if (it.command == pjd_pkg::CMD_FREE && $urandom_range(0, 3) != 0)
            it.worker_index = 4'($urandom_range(0, active_workers - 1));
        return it;
    endfunction

    // Write both registers; the block is idle here
    task automatic set_config(logic [4:0] wc, logic mt);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= pjd_pkg::CFG_WORKER_COUNT;
        cfg_data <= wc;
        active_workers = (wc == 0) ? 1 : (wc > NUM_WORKERS) ? NUM_WORKERS : int'(wc);
        @(posedge clk);
        cfg_index <= pjd_pkg::CFG_MULTITHREAD;
        cfg_data <= {4'd0, mt};
        multithread = mt;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every item is sent and every result seen, then let the pass settle
    task automatic drain_phase();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int count, int flood);
        repeat (count) pending_items.push_back(random_item(flood));
        drain_phase();
    endtask

    initial
    begin
        busy_mask = '0;
        handle_ctr = '0;
        active_workers = 1;
        multithread = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset configuration: one worker taking every type
        pending_items.push_back(mk_item(pjd_pkg::CMD_SUBMIT, 3'd7, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_SUBMIT, 3'd1, pjd_pkg::PRIO_HIGH,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_SUBMIT, 3'd2, pjd_pkg::PRIO_HIGH,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_SUBMIT, 3'd4, pjd_pkg::PRIO_HIGH,
                                        1'b1, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_SUBMIT, 3'd3, PRIO_NORMAL,
                                        1'b1, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_SUBMIT, 3'd0, PRIO_LOW,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_DISPATCH, 3'd0, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_FREE, 3'd0, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_DISPATCH, 3'd7, pjd_pkg::PRIO_HIGH,
                                        1'b1, 4'd15));
        pending_items.push_back(mk_item(pjd_pkg::CMD_FREE, 3'd0, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_FREE, 3'd0, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_FREE, 3'd7, pjd_pkg::PRIO_HIGH,
                                        1'b1, 4'd15));
        pending_items.push_back(mk_item(CMD_UNUSED, 3'd7, pjd_pkg::PRIO_HIGH,
                                        1'b1, 4'd15));
        pending_items.push_back(mk_item(pjd_pkg::CMD_DISPATCH, 3'd0, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_FREE, 3'd0, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_DISPATCH, 3'd0, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_FREE, 3'd0, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_DISPATCH, 3'd0, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_FREE, 3'd0, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        pending_items.push_back(mk_item(pjd_pkg::CMD_DISPATCH, 3'd0, pjd_pkg::PRIO_NONE,
                                        1'b0, 4'd0));
        drain_phase();

        // Random phases across worker counts, saturating writes included
        set_config(5'd2, 1'b1);
        random_phase(60, 0);
        set_config(5'd0, 1'b1);
        random_phase(40, 0);
        set_config(5'd31, 1'b1);
        random_phase(60, 0);
        // Flood the low queue behind its stuck head until it overflows
        set_config(5'd3, 1'b1);
        random_phase(140, 1);
        calm = 1;
        set_config(5'd16, 1'b0);
        random_phase(30, 0);

        $display("Sent %0d items and checked %0d results over six worker setups,",
                 items_sent, results_seen);
        $display("including queue overflow, stuck queue heads and saturating writes.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
